// File: rtl/sgd_pkg.sv
// Shared types and constants for the grouped decimal total formatter.
// No dependencies; every other file of the block imports this package.
package sgd_pkg;

    // Fixed channel widths
    localparam int DELTA_W    = 32;
    localparam int TOTAL_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_START_VALUE = 1'b0;
    localparam cfg_idx_t CFG_GROUP_SEP   = 1'b1;

    // Characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] SEP_RESET  = 8'h2C;

    // Binary to BCD conversion: bits consumed per cycle and digit arithmetic
    localparam int         DD_STEP  = 4;
    localparam int         BCD_W    = 4;
    localparam logic [3:0] BCD_FIVE = 4'd5;
    localparam logic [3:0] BCD_ADJ  = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic add;
        logic load_mag;
        logic dabble;
        logic find_top;
        logic emit_sign;
        logic emit_digit;
        logic emit_sep;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic conv_last;
        logic neg;
        logic sep_here;
        logic pos_zero;
        logic out_free;
    } status_t;

endpackage

// File: rtl/sgd_if.sv
// Channel interfaces: delta input, character output and configuration write.
// Depends on sgd_pkg for payload widths and the register index type.
interface sgd_delta_if;
    import sgd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] delta;

    modport source (output valid, output delta, input ready);
    modport sink   (input valid, input delta, output ready);
endinterface

interface sgd_text_if;
    import sgd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CHAR_W-1:0]         text_char;
    logic signed [TOTAL_W-1:0] total;
    logic                      last_char;

    modport source (output valid, output text_char, output total, output last_char,
                    input ready);
    modport sink   (input valid, input text_char, input total, input last_char,
                    output ready);
endinterface

interface sgd_cfg_if;
    import sgd_pkg::*;

    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sgd_ctrl.sv
// Sequencing state machine for the grouped decimal total formatter.
// Depends on sgd_pkg for the command and status structs.
module sgd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sgd_pkg::status_t status,
    output sgd_pkg::cmd_t    cmd
);
    import sgd_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_CONV  = 7'b0000100,
        ST_COUNT = 7'b0001000,
        ST_SIGN  = 7'b0010000,
        ST_DIGIT = 7'b0100000,
        ST_SEP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new delta only between transactions
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.add    = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_mag = 1'b1;
                state_next   = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (status.conv_last)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.find_top = 1'b1;
                state_next   = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.sep_here)
                    begin
                        state_next = ST_SEP;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_SEP:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sep = 1'b1;
                    state_next   = ST_DIGIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sgd_datapath.sv
// Datapath: running total, BCD conversion, digit position tracking and output register.
// Depends on sgd_pkg and on the channel interfaces in sgd_if.sv.
module sgd_datapath #(
    parameter int VALUE_BITS = 32,
    parameter int GROUP_SIZE = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [sgd_pkg::DELTA_W-1:0] delta,
    input  sgd_pkg::cmd_t                      cmd,
    output sgd_pkg::status_t                   status,
    sgd_text_if.source                         text_ch,
    sgd_cfg_if.sink                            cfg_ch
);
    import sgd_pkg::*;

    // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
    localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int POS_W = $clog2(NDIG);
    localparam int STEPS = (VALUE_BITS + DD_STEP - 1) / DD_STEP;
    localparam int PAD_W = STEPS * DD_STEP;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic signed [VALUE_BITS-1:0]   total_reg;
    logic [CHAR_W-1:0]              sep_reg;
    logic                           neg_reg;
    logic [PAD_W-1:0]               mag_reg;
    logic [NDIG-1:0][BCD_W-1:0]     bcd_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [POS_W-1:0]               pos_reg;
    logic                           out_valid_reg;
    logic [CHAR_W-1:0]              out_char_reg;
    logic signed [TOTAL_W-1:0]      out_total_reg;
    logic                           out_last_reg;

    logic [VALUE_BITS-1:0]          total_bits;
    logic [VALUE_BITS-1:0]          mag_abs;
    logic [NDIG-1:0][BCD_W-1:0]     bcd_next;
    logic [PAD_W-1:0]               mag_next;
    logic [POS_W-1:0]               top_pos;
    logic [NDIG-1:0]                sep_mark;
    logic                           out_free;
    logic                           emit;
    logic                           cfg_wr;

    // Separator follows a digit whose place is a whole number of groups up
    for (genvar p = 0; p < NDIG; p++)
    begin : g_sep
        localparam int PHASE = p % GROUP_SIZE;
        assign sep_mark[p] = (p != 0) && (PHASE == 0);
    end

    // Magnitude of the total; the most negative value comes out as 2^(n-1)
    assign total_bits = total_reg;
    assign mag_abs    = total_bits[VALUE_BITS-1] ? (~total_bits + 1'b1) : total_bits;

    // Shift-and-add-3 over DD_STEP bits per cycle
    always_comb
    begin
        bcd_next = bcd_reg;
        mag_next = mag_reg;
        for (int k = 0; k < DD_STEP; k++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_next[d] >= BCD_FIVE)
                begin
                    bcd_next[d] = bcd_next[d] + BCD_ADJ;
                end
            end
            {bcd_next, mag_next} = {bcd_next, mag_next} << 1;
        end
    end

    // Highest non-zero digit; zero gives place 0
    always_comb
    begin
        top_pos = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d] != '0)
            begin
                top_pos = POS_W'(d);
            end
        end
    end

    assign out_free = !out_valid_reg || text_ch.ready;
    assign emit     = cmd.emit_sign || cmd.emit_digit || cmd.emit_sep;
    assign cfg_wr   = cfg_ch.valid && cfg_ch.ready;

    assign status.conv_last = (cnt_reg == CNT_LAST);
    assign status.neg       = neg_reg;
    assign status.sep_here  = sep_mark[pos_reg];
    assign status.pos_zero  = (pos_reg == '0);
    assign status.out_free  = out_free;

    assign cfg_ch.ready = 1'b1;

    assign text_ch.valid     = out_valid_reg;
    assign text_ch.text_char = out_char_reg;
    assign text_ch.total     = out_total_reg;
    assign text_ch.last_char = out_last_reg;

    // Running total, separator register, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            sep_reg       <= SEP_RESET;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (cfg_ch.index == CFG_START_VALUE))
            begin
                total_reg <= VALUE_BITS'($signed(cfg_ch.data));
            end
            else if (cmd.add)
            begin
                total_reg <= total_reg + VALUE_BITS'(delta);
            end

            if (cfg_wr && (cfg_ch.index == CFG_GROUP_SEP))
            begin
                sep_reg <= cfg_ch.data[CHAR_W-1:0];
            end

            if (cmd.load_mag)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.dabble)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            // Step down one place after a digit, or after its separator
            if (cmd.find_top)
            begin
                pos_reg <= top_pos;
            end
            else if (cmd.emit_sep || (cmd.emit_digit && !sep_mark[pos_reg]
                                      && (pos_reg != '0)))
            begin
                pos_reg <= pos_reg - 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Conversion registers and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_mag)
        begin
            neg_reg <= total_bits[VALUE_BITS-1];
            mag_reg <= PAD_W'(mag_abs);
            bcd_reg <= '0;
        end
        else if (cmd.dabble)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end

        if (emit)
        begin
            out_total_reg <= TOTAL_W'(total_reg);
            out_last_reg  <= cmd.emit_digit && (pos_reg == '0);
            if (cmd.emit_sign)
            begin
                out_char_reg <= CHAR_MINUS;
            end
            else if (cmd.emit_digit)
            begin
                out_char_reg <= CHAR_ZERO + {{(CHAR_W - BCD_W){1'b0}}, bcd_reg[pos_reg]};
            end
            else
            begin
                out_char_reg <= sep_reg;
            end
        end
    end

endmodule

// File: rtl/signed_total_to_grouped_decimal.sv
// Top level: signed running total printed as grouped decimal characters.
// Depends on sgd_pkg, sgd_if.sv, sgd_ctrl and sgd_datapath.
//
//   channel   role    payload                        transaction
//   delta_ch  sink    delta                          one delta added to the total
//   text_ch   source  text_char, total, last_char    one character of the text
//   cfg_ch    sink    index, data                    one register write
//
// An item is added to the total, its magnitude is formed, it is converted to BCD
// 4 bits a cycle, the leading digit is found, and then one character is sent
// per cycle while text_ch does not stall.
// Reset loads the total with 0 and the separator with a comma.
// A stall on text_ch holds the current character and pauses the sequencer;
// the next delta is taken once the last character sits in the output register.
module signed_total_to_grouped_decimal #(
    parameter int VALUE_BITS = 32,
    parameter int GROUP_SIZE = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    sgd_delta_if.sink  delta_ch,
    sgd_text_if.source text_ch,
    sgd_cfg_if.sink    cfg_ch
);
    import sgd_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign delta_ch.ready = in_ready;

    // Sequencer
    sgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (delta_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Total, conversion and output register
    sgd_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .delta   (delta_ch.delta),
        .cmd     (cmd),
        .status  (status),
        .text_ch (text_ch),
        .cfg_ch  (cfg_ch)
    );

endmodule

// File: test/signed_total_to_grouped_decimal_tb.sv
`timescale 1ns / 100ps
// Testbench for signed_total_to_grouped_decimal: random and directed deltas,
// register writes between phases, and a scoreboard that predicts every character.
// Depends on sgd_pkg, the channel interfaces in sgd_if.sv and the block's top level.

import sgd_pkg::*;

// One predicted character of the formatted total
typedef struct {
    logic [CHAR_W-1:0]         text_char;
    logic signed [TOTAL_W-1:0] total;
    logic                      last_char;
} text_beat_t;

// Running total, separator and the queue of characters still to arrive
class grouped_text_board;
    int                        errors;
    logic signed [TOTAL_W-1:0] total;
    logic [CHAR_W-1:0]         separator;
    int                        group_len;
    text_beat_t                pending_chars[$];

    function new(int grp);
        errors    = 0;
        total     = '0;
        separator = SEP_RESET;
        group_len = grp;
    endfunction

    function void load_start(logic [CFG_DATA_W-1:0] value);
        total = value;
    endfunction

    function void set_separator(logic [CHAR_W-1:0] value);
        separator = value;
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction

    // Add the delta and queue the decimal text of the new total
    function void note_delta(logic signed [DELTA_W-1:0] delta);
        logic [TOTAL_W-1:0] mag;
        logic [CHAR_W-1:0]  rev[$];
        int                 in_group;
        logic               neg;
        text_beat_t         beat;
        total    = total + delta;
        neg      = total[TOTAL_W-1];
        mag      = neg ? (~total + 1'b1) : total;
        in_group = 0;
        // build least significant digit first
        do
        begin
            rev.push_back(CHAR_ZERO + 8'(mag % 10));
            in_group++;
            mag = mag / 10;
            if (mag != 0 && in_group == group_len)
            begin
                in_group = 0;
                rev.push_back(separator);
            end
        end while (mag != 0);
        if (neg)
            rev.push_back(CHAR_MINUS);
        for (int k = rev.size() - 1; k >= 0; k--)
        begin
            beat.text_char = rev[k];
            beat.total     = total;
            beat.last_char = (k == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    // Compare one accepted character with the oldest prediction
    function void check_char(logic [CHAR_W-1:0] text_char, logic signed [TOTAL_W-1:0] tot,
                             logic last_char);
        text_beat_t beat;
        if (pending_chars.size() == 0)
        begin
            $display("%0t: unexpected character %h total %0d last %b",
                     $time, text_char, tot, last_char);
            errors++;
            return;
        end
        beat = pending_chars.pop_front();
        if (text_char !== beat.text_char)
        begin
            $display("%0t: text_char expected %h actual %h", $time, beat.text_char, text_char);
            errors++;
        end
        if (tot !== beat.total)
        begin
            $display("%0t: total expected %0d actual %0d", $time, beat.total, tot);
            errors++;
        end
        if (last_char !== beat.last_char)
        begin
            $display("%0t: last_char expected %b actual %b", $time, beat.last_char, last_char);
            errors++;
        end
    endfunction
endclass

module signed_total_to_grouped_decimal_tb;

    localparam int VALUE_W   = 32;
    localparam int GROUP_LEN = 3;
    // cycles to let the block settle before a register write or the end
    localparam int SETTLE    = 40;
    localparam int PHASE_LEN = 125;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    grouped_text_board board;

    sgd_delta_if delta_ch ();
    sgd_text_if  text_ch ();
    sgd_cfg_if   cfg_ch ();

    signed_total_to_grouped_decimal #(
        .VALUE_BITS (VALUE_W),
        .GROUP_SIZE (GROUP_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .delta_ch (delta_ch),
        .text_ch  (text_ch),
        .cfg_ch   (cfg_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Drive receiver ready at the falling edge
    initial
    begin
        text_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            text_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted character
    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
            board.check_char(text_ch.text_char, text_ch.total, text_ch.last_char);
    end

    // Offer one delta, with random idle cycles ahead of it
    task automatic send_delta(logic [DELTA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            delta_ch.valid = 1'b0;
        end
        @(negedge clk);
        delta_ch.valid = 1'b1;
        delta_ch.delta = value;
        @(posedge clk);
        while (!delta_ch.ready)
            @(posedge clk);
        board.note_delta(value);
    endtask

    // Hold off new deltas until every predicted character has arrived
    task automatic drain_text();
        @(negedge clk);
        delta_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Write one register once the block is idle
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        drain_text();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_START_VALUE)
            board.load_start(value);
        else
            board.set_separator(value[CHAR_W-1:0]);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Pick a delta: mostly short texts, some full width, some steered to the extremes
    function automatic logic [DELTA_W-1:0] pick_delta();
        logic [DELTA_W-1:0] value;
        case ($urandom_range(9))
            0, 1, 2: value = $urandom_range(2000) - 1000;
            3:       value = $urandom_range(20) - 10;
            4:       value = $urandom_range(2_000_000) - 1_000_000;
            5, 6:    value = $urandom;
            7:       value = 32'(0 - board.total + ($urandom_range(20) - 10));
            8:       value = 32'h7FFF_FFFF - board.total + $urandom_range(1);
            default:
            begin
                case ($urandom_range(4))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    3:       value = 32'h0000_0001;
                    default: value = '0;
                endcase
            end
        endcase
        return value;
    endfunction

    // Random phase with one mid-phase drain
    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain_text();
            send_delta(pick_delta());
        end
    endtask

    // Main sequence
    initial
    begin
        board          = new(GROUP_LEN);
        send_idle_pct  = 17;
        recv_idle_pct  = 82;
        rst_n          = 1'b0;
        delta_ch.valid = 1'b0;
        delta_ch.delta = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_START_VALUE;
        cfg_ch.data    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (SETTLE) @(posedge clk);

        // Reset settings: zero, group boundaries, wrap both ways
        send_delta(32'd0);
        send_delta(32'd7);
        send_delta(32'd993);
        send_delta(-32'sd1000);
        send_delta(32'h8000_0000);
        send_delta(32'hFFFF_FFFF);
        send_delta(32'd1);
        send_delta(32'd0);
        send_delta(32'h7FFF_FFFF);
        send_delta(32'd999);
        send_delta(32'd1);
        send_delta(32'd998_999);

        // Largest start, null separator
        write_reg(CFG_START_VALUE, 32'h7FFF_FFFF);
        write_reg(CFG_GROUP_SEP, 32'h0000_0000);
        send_delta(32'd0);
        send_delta(32'd1);
        send_delta(32'h7FFF_FFFF);

        // Most negative start, all-ones separator
        write_reg(CFG_START_VALUE, 32'h8000_0000);
        write_reg(CFG_GROUP_SEP, 32'h0000_00FF);
        send_delta(32'd0);
        send_delta(32'hFFFF_FFFF);
        send_delta(32'h5555_5555);
        send_delta(32'hAAAA_AAAA);

        // Sender light, receiver heavy
        write_reg(CFG_START_VALUE, $urandom);
        write_reg(CFG_GROUP_SEP, 32'(SEP_RESET));
        run_random(PHASE_LEN);

        // Sender heavy, receiver light
        drain_text();
        send_idle_pct = 82;
        recv_idle_pct = 17;
        write_reg(CFG_START_VALUE, $urandom_range(2000) - 1000);
        write_reg(CFG_GROUP_SEP, $urandom_range(255));
        run_random(PHASE_LEN);

        // No idling on either side
        drain_text();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_START_VALUE, $urandom);
        write_reg(CFG_GROUP_SEP, $urandom_range(255));
        run_random(PHASE_LEN);

        // Drain and let any stray character show up
        drain_text();
        repeat (SETTLE) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0t: %0d characters never arrived", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: signed_total_to_grouped_decimal.f
rtl/sgd_pkg.sv
rtl/sgd_if.sv
rtl/sgd_ctrl.sv
rtl/sgd_datapath.sv
rtl/signed_total_to_grouped_decimal.sv
test/signed_total_to_grouped_decimal_tb.sv
